>>> src/ftsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsm_pkg
// Widths, event codes and transaction types for the frame time statistics
// monitor.
// ----------------------------------------------------------------------------
package ftsm_pkg;

    localparam int DURATION_BITS = 32;
    localparam int COUNT_BITS    = 16;
    localparam int FRACTION_BITS = 8;
    localparam int SUM_BITS      = 48;
    localparam int TICK_BITS     = 32;
    localparam int MEAN_BITS     = DURATION_BITS + FRACTION_BITS;

    // dividend of the mean: window sum with the fraction bits appended
    localparam int NUM_BITS      = SUM_BITS + FRACTION_BITS;
    localparam int STEP_BITS     = $clog2(NUM_BITS);

    localparam logic [TICK_BITS-1:0] WINDOW_TICKS_RESET = TICK_BITS'(1000);

    // event codes
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [DURATION_BITS-1:0] frame_duration;
    } ftsm_in_t;

    typedef struct packed {
        logic                     window_closed;
        logic [COUNT_BITS-1:0]    frames_in_window;
        logic [COUNT_BITS-1:0]    peak_rate;
        logic [COUNT_BITS-1:0]    lowest_rate;
        logic [DURATION_BITS-1:0] last_duration;
        logic [DURATION_BITS-1:0] longest_duration;
        logic [DURATION_BITS-1:0] shortest_duration;
        logic [MEAN_BITS-1:0]     average_duration;
    } ftsm_out_t;

endpackage

>>> src/frame_time_statistics_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_statistics_monitor_unit
// Frame duration statistics over tick-counted windows, mean by a bit-serial
// divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries events (frame report, timer tick, restart) in one struct;
//   m_* returns one statistics snapshot per event. cfg_* writes the window
//   length in ticks and is always ready; write it only while the block idles.
// Sequencing:
//   A tick, restart or frame that leaves the window open is registered and
//   then emitted; m_valid and s_ready rise together once the output register
//   is free, and no new event is taken before then. A frame that closes a
//   window first runs the restoring divider, one quotient bit per cycle over
//   the 56-bit dividend, and is then emitted in the same way.
//   s_ready is high whenever no event is being processed, including while a
//   finished snapshot waits in the output register.
// Reset:
//   aresetn (synchronous, active low) clears all statistics and the output
//   valid and sets the window length to 1000 ticks.
// Stall:
//   While m_ready is low the snapshot holds; one more event may be taken and
//   then waits for the output register before s_ready rises again.
// ----------------------------------------------------------------------------
module frame_time_statistics_monitor_unit
    import ftsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TICK_BITS-1:0] cfg_data,
    // events
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ftsm_in_t             s_data,
    // statistics
    output logic                 m_valid,
    input  logic                 m_ready,
    output ftsm_out_t            m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int DIV_BITS = COUNT_BITS + NUM_BITS;

    logic [1:0]               state_reg, state_next;
    logic [TICK_BITS-1:0]     window_ticks_reg, window_ticks_next;
    logic [TICK_BITS-1:0]     elapsed_reg, elapsed_next;
    logic [COUNT_BITS-1:0]    frames_reg, frames_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [DURATION_BITS-1:0] recent_reg, recent_next;
    logic [DURATION_BITS-1:0] max_dur_reg, max_dur_next;
    logic [DURATION_BITS-1:0] min_dur_reg, min_dur_next;
    logic [COUNT_BITS-1:0]    latched_reg, latched_next;
    logic [COUNT_BITS-1:0]    max_rate_reg, max_rate_next;
    logic [COUNT_BITS-1:0]    min_rate_reg, min_rate_next;
    logic [MEAN_BITS-1:0]     mean_reg, mean_next;
    logic                     closed_reg, closed_next;
    logic [DIV_BITS-1:0]      div_reg, div_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic                     m_valid_reg, m_valid_next;
    ftsm_out_t                m_data_reg, m_data_next;

    logic                     s_fire;
    logic [COUNT_BITS:0]      frames_inc;
    logic [COUNT_BITS-1:0]    frames_sat;
    logic [SUM_BITS:0]        sum_add;
    logic [SUM_BITS-1:0]      sum_sat;
    logic [TICK_BITS:0]       elapsed_inc;
    logic [DIV_BITS:0]        div_shift;
    logic [COUNT_BITS:0]      div_trial;
    logic [COUNT_BITS:0]      div_diff;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // saturating updates of the window counters
    assign frames_inc  = {1'b0, frames_reg} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign frames_sat  = frames_inc[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                                : frames_inc[COUNT_BITS-1:0];
    assign sum_add     = {1'b0, sum_reg}
                       + {{(SUM_BITS - DURATION_BITS + 1){1'b0}}, s_data.frame_duration};
    assign sum_sat     = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
    assign elapsed_inc = {1'b0, elapsed_reg} + {{TICK_BITS{1'b0}}, 1'b1};

    // restoring divider step: remainder in the top bits, dividend shifting out
    // at the top of the low part and quotient bits entering at the bottom
    assign div_shift = {div_reg, 1'b0};
    assign div_trial = div_shift[DIV_BITS:NUM_BITS];
    assign div_diff  = div_trial - {1'b0, latched_reg};

    always_comb begin
        state_next        = state_reg;
        window_ticks_next = window_ticks_reg;
        elapsed_next      = elapsed_reg;
        frames_next       = frames_reg;
        sum_next          = sum_reg;
        recent_next       = recent_reg;
        max_dur_next      = max_dur_reg;
        min_dur_next      = min_dur_reg;
        latched_next      = latched_reg;
        max_rate_next     = max_rate_reg;
        min_rate_next     = min_rate_reg;
        mean_next         = mean_reg;
        closed_next       = closed_reg;
        div_next          = div_reg;
        step_next         = step_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;

        // configuration write
        if (cfg_valid) begin
            window_ticks_next = cfg_data;
        end

        // output register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    closed_next = 1'b0;
                    state_next  = ST_EMIT;
                    case (s_data.kind)
                        KIND_FRAME: begin
                            recent_next = s_data.frame_duration;
                            if (s_data.frame_duration > max_dur_reg) begin
                                max_dur_next = s_data.frame_duration;
                            end
                            if (min_dur_reg == '0 || s_data.frame_duration < min_dur_reg) begin
                                min_dur_next = s_data.frame_duration;
                            end
                            if (elapsed_reg >= window_ticks_reg) begin
                                // window close: latch rate, start mean division
                                closed_next  = 1'b1;
                                elapsed_next = '0;
                                frames_next  = '0;
                                sum_next     = '0;
                                latched_next = frames_sat;
                                if (max_rate_reg < frames_sat) begin
                                    max_rate_next = frames_sat;
                                end
                                if (min_rate_reg == '0 || min_rate_reg > frames_sat) begin
                                    min_rate_next = frames_sat;
                                end
                                div_next   = {{COUNT_BITS{1'b0}}, sum_sat,
                                              {FRACTION_BITS{1'b0}}};
                                step_next  = STEP_BITS'(NUM_BITS - 1);
                                state_next = ST_DIV;
                            end else begin
                                frames_next = frames_sat;
                                sum_next    = sum_sat;
                            end
                        end
                        KIND_TICK: begin
                            elapsed_next = elapsed_inc[TICK_BITS] ? {TICK_BITS{1'b1}}
                                                                  : elapsed_inc[TICK_BITS-1:0];
                        end
                        KIND_RESTART: begin
                            elapsed_next = '0;
                            frames_next  = '0;
                            sum_next     = '0;
                            max_dur_next = '0;
                            min_dur_next = '0;
                            latched_next = '0;
                            mean_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_DIV: begin
                if (div_trial >= {1'b0, latched_reg}) begin
                    div_next = {div_diff[COUNT_BITS-1:0], div_shift[NUM_BITS-1:1], 1'b1};
                end else begin
                    div_next = div_shift[DIV_BITS-1:0];
                end
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == '0) begin
                    // quotient complete: saturate to the mean width
                    if (div_next[NUM_BITS-1:MEAN_BITS] != '0) begin
                        mean_next = {MEAN_BITS{1'b1}};
                    end else begin
                        mean_next = div_next[MEAN_BITS-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_data_next.window_closed     = closed_reg;
                    m_data_next.frames_in_window  = latched_reg;
                    m_data_next.peak_rate         = max_rate_reg;
                    m_data_next.lowest_rate       = min_rate_reg;
                    m_data_next.last_duration     = recent_reg;
                    m_data_next.longest_duration  = max_dur_reg;
                    m_data_next.shortest_duration = min_dur_reg;
                    m_data_next.average_duration  = mean_reg;
                    state_next                    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and statistics state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            window_ticks_reg <= WINDOW_TICKS_RESET;
            elapsed_reg      <= '0;
            frames_reg       <= '0;
            sum_reg          <= '0;
            recent_reg       <= '0;
            max_dur_reg      <= '0;
            min_dur_reg      <= '0;
            latched_reg      <= '0;
            max_rate_reg     <= '0;
            min_rate_reg     <= '0;
            mean_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            window_ticks_reg <= window_ticks_next;
            elapsed_reg      <= elapsed_next;
            frames_reg       <= frames_next;
            sum_reg          <= sum_next;
            recent_reg       <= recent_next;
            max_dur_reg      <= max_dur_next;
            min_dur_reg      <= min_dur_next;
            latched_reg      <= latched_next;
            max_rate_reg     <= max_rate_next;
            min_rate_reg     <= min_rate_next;
            mean_reg         <= mean_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload and divider datapath
    always_ff @(posedge aclk) begin
        closed_reg <= closed_next;
        div_reg    <= div_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

endmodule
